>>> rtl/mrmt_pkg.sv
package mrmt_pkg;

   // frame identifier base of motor replies
   localparam int unsigned REPLY_ID_BASE = 320;

   // register widths
   localparam int unsigned ID_W      = 11;
   localparam int unsigned MOTOR_W   = 5;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned CENC_W    = 17;
   localparam int unsigned POS_W     = 33;
   localparam int unsigned CSR_IDX_W = 2;

   // register reset values
   localparam logic [MOTOR_W-1:0] MOTOR_ID_RESET  = 5'd1;
   localparam logic [WORD_W-1:0]  OFFSET_RESET    = 16'd0;
   localparam logic [WORD_W-1:0]  THRESHOLD_RESET = 16'd3641;

   // revolution count limits
   localparam logic [WORD_W-1:0] REV_MAX = 16'h7FFF;
   localparam logic [WORD_W-1:0] REV_MIN = 16'h8000;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOTOR_ID  = 2'd0,
      CSR_OFFSET    = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   // one classified frame, front to back
   typedef struct packed {
      logic                     matched;
      logic [WORD_W-1:0]        speed;
      logic signed [CENC_W-1:0] cenc;
   } item_type;

   // queue status
   typedef struct packed {
      logic [1:0] count;
      logic       empty;
      logic       full;
   } q_status_type;

endpackage

>>> rtl/mrmt_front.sv
module mrmt_front (
   input  logic [mrmt_pkg::ID_W-1:0]    frame_id,
   input  logic [mrmt_pkg::WORD_W-1:0]  speed_word,
   input  logic [mrmt_pkg::WORD_W-1:0]  encoder_word,
   input  logic [mrmt_pkg::MOTOR_W-1:0] motor_id,
   input  logic [mrmt_pkg::WORD_W-1:0]  encoder_offset,
   output mrmt_pkg::item_type           item
);

   logic [mrmt_pkg::ID_W:0] match_id;

   // match without wrap: a sum past the id range never matches
   assign match_id = (mrmt_pkg::ID_W+1)'(mrmt_pkg::REPLY_ID_BASE)
                   + {{(mrmt_pkg::ID_W+1-mrmt_pkg::MOTOR_W){1'b0}}, motor_id};

   // classify and correct the encoder reading once
   always_comb begin
      item.matched = ({1'b0, frame_id} == match_id);
      item.speed   = speed_word;
      item.cenc    = $signed({1'b0, encoder_word}) - $signed({1'b0, encoder_offset});
   end

endmodule

>>> rtl/mrmt_queue.sv
module mrmt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mrmt_pkg::item_type     push_item,
   input  logic                   pop,
   output mrmt_pkg::item_type     pop_item,
   output mrmt_pkg::q_status_type status
);

   mrmt_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

>>> rtl/mrmt_back.sv
module mrmt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  mrmt_pkg::item_type           item,
   output logic                         item_take,
   input  logic [mrmt_pkg::WORD_W-1:0]  jump_threshold,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_id_matched,
   output logic [mrmt_pkg::WORD_W-1:0]  rsp_speed_out,
   output logic signed [mrmt_pkg::POS_W-1:0]  rsp_position_counts,
   output logic signed [mrmt_pkg::WORD_W-1:0] rsp_turn_count
);

   localparam int unsigned DW = mrmt_pkg::POS_W + 1;

   // unwrap state
   logic [mrmt_pkg::WORD_W-1:0] rev_ff, rev_in;
   logic [mrmt_pkg::POS_W-1:0]  prev_ff, prev_in;
   logic [mrmt_pkg::CENC_W-1:0] cenc_ff, cenc_in;
   logic [mrmt_pkg::WORD_W-1:0] speed_ff, speed_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        matched_ff;
   logic [mrmt_pkg::WORD_W-1:0] out_speed_ff;
   logic [mrmt_pkg::POS_W-1:0]  out_pos_ff;
   logic [mrmt_pkg::WORD_W-1:0] out_rev_ff;

   logic [mrmt_pkg::POS_W-1:0]  pos0, pos1, pos2;
   logic [mrmt_pkg::WORD_W-1:0] rev1;
   logic [DW-1:0]               thr_x, d0, d1, s0, s1;
   logic                        inc, dec;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   // two wrap checks in order against the previous position
   always_comb begin
      cenc_in  = item.matched ? item.cenc  : cenc_ff;
      speed_in = item.matched ? item.speed : speed_ff;
      thr_x    = {{(DW-mrmt_pkg::WORD_W){1'b0}}, jump_threshold};

      pos0 = {rev_ff[mrmt_pkg::WORD_W-1], rev_ff, 16'h0000}
           + {{(mrmt_pkg::POS_W-mrmt_pkg::CENC_W){cenc_in[mrmt_pkg::CENC_W-1]}}, cenc_in};
      d0   = {pos0[mrmt_pkg::POS_W-1], pos0} - {prev_ff[mrmt_pkg::POS_W-1], prev_ff};
      s0   = d0 + thr_x;                       // negative: fell past threshold
      inc  = s0[DW-1] && (rev_ff != mrmt_pkg::REV_MAX);
      rev1 = inc ? rev_ff + 16'd1 : rev_ff;
      pos1 = inc ? pos0 + 33'h0_0001_0000 : pos0;

      d1   = {pos1[mrmt_pkg::POS_W-1], pos1} - {prev_ff[mrmt_pkg::POS_W-1], prev_ff};
      s1   = thr_x - d1;                       // negative: rose past threshold
      dec  = s1[DW-1] && (rev1 != mrmt_pkg::REV_MIN);
      rev_in  = dec ? rev1 - 16'd1 : rev1;
      pos2    = dec ? pos1 - 33'h0_0001_0000 : pos1;
      prev_in = pos2;

      rsp_valid_in = item_take || (rsp_valid_ff && !rsp_ready);
   end

   // control state and unwrap state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rev_ff       <= '0;
         prev_ff      <= '0;
         cenc_ff      <= '0;
         speed_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            rev_ff   <= rev_in;
            prev_ff  <= prev_in;
            cenc_ff  <= cenc_in;
            speed_ff <= speed_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (item_take) begin
         matched_ff   <= item.matched;
         out_speed_ff <= speed_in;
         out_pos_ff   <= pos2;
         out_rev_ff   <= rev_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_id_matched      = matched_ff;
   assign rsp_speed_out       = out_speed_ff;
   assign rsp_position_counts = $signed(out_pos_ff);
   assign rsp_turn_count      = $signed(out_rev_ff);

endmodule

>>> rtl/motor_reply_multiturn_tracker_core.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  frame_id, speed_word, encoder_word
// rsp_      out        rsp_valid / rsp_ready  id_matched, speed_out, position_counts,
//                                             turn_count
// csr_      in         csr_valid / csr_ready  csr_index, csr_data (always ready)
//
// One beat per cycle sustained while rsp_ready holds; a request beat is written into
// the queue, then taken into the result register, which drives rsp_valid.
// The unwrap state update is combinational in the back end, registered per taken item.
// Synchronous active-high reset clears the queue, the unwrap state and rsp_valid and
// resets the config registers. A stalled rsp_ready fills the queue, then drops req_ready.
module motor_reply_multiturn_tracker_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mrmt_pkg::ID_W-1:0]          req_frame_id,
   input  logic [mrmt_pkg::WORD_W-1:0]        req_speed_word,
   input  logic [mrmt_pkg::WORD_W-1:0]        req_encoder_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_id_matched,
   output logic [mrmt_pkg::WORD_W-1:0]        rsp_speed_out,
   output logic signed [mrmt_pkg::POS_W-1:0]  rsp_position_counts,
   output logic signed [mrmt_pkg::WORD_W-1:0] rsp_turn_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mrmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrmt_pkg::WORD_W-1:0]        csr_data
);

   logic [mrmt_pkg::MOTOR_W-1:0] motor_id_ff;
   logic [mrmt_pkg::WORD_W-1:0]  offset_ff;
   logic [mrmt_pkg::WORD_W-1:0]  threshold_ff;

   mrmt_pkg::item_type     front_item, back_item;
   mrmt_pkg::q_status_type q_status;
   logic                   push, pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_id_ff  <= mrmt_pkg::MOTOR_ID_RESET;
         offset_ff    <= mrmt_pkg::OFFSET_RESET;
         threshold_ff <= mrmt_pkg::THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mrmt_pkg::CSR_MOTOR_ID:  motor_id_ff  <= csr_data[mrmt_pkg::MOTOR_W-1:0];
            mrmt_pkg::CSR_OFFSET:    offset_ff    <= csr_data;
            mrmt_pkg::CSR_THRESHOLD: threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // front end: match and encoder correction
   mrmt_front u_front (
      .frame_id       (req_frame_id),
      .speed_word     (req_speed_word),
      .encoder_word   (req_encoder_word),
      .motor_id       (motor_id_ff),
      .encoder_offset (offset_ff),
      .item           (front_item)
   );

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   mrmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (back_item),
      .status    (q_status)
   );

   // back end: unwrap and result register
   mrmt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (!q_status.empty),
      .item                (back_item),
      .item_take           (pop),
      .jump_threshold      (threshold_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_id_matched      (rsp_id_matched),
      .rsp_speed_out       (rsp_speed_out),
      .rsp_position_counts (rsp_position_counts),
      .rsp_turn_count      (rsp_turn_count)
   );

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_status.count != 2'd2))
      else $error("queue pushed while full");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_status.count == $past(q_status.count) + 2'd1))
      else $error("queue count lost a push");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (q_status.empty && !rsp_valid))
      else $error("state not cleared by reset");
`endif

endmodule

>>> bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TURN_MAX = int'($signed(mrmt_pkg::REV_MAX));
   localparam int TURN_MIN = int'($signed(mrmt_pkg::REV_MIN));
   // one third of a turn, used to spin the shaft at full rate
   localparam int SPIN_STEP = 21845;

   // one reply as seen on the rsp_ channel
   typedef struct packed {
      logic                               matched;
      logic [mrmt_pkg::WORD_W-1:0]        speed;
      logic signed [mrmt_pkg::POS_W-1:0]  pos;
      logic signed [mrmt_pkg::WORD_W-1:0] turns;
   } reply_type;

   // unwrap predictor plus the queue of replies still owed by the block
   class tracker_scoreboard_type;
      logic [mrmt_pkg::MOTOR_W-1:0] motor_id;
      logic [mrmt_pkg::WORD_W-1:0]  enc_offset;
      logic [mrmt_pkg::WORD_W-1:0]  jump_thr;
      int                           revs;
      longint                       prev_pos;
      int                           cenc;
      logic [mrmt_pkg::WORD_W-1:0]  last_speed;
      reply_type                    owed[$];
      int                           errors;

      function new();
         motor_id   = mrmt_pkg::MOTOR_ID_RESET;
         enc_offset = mrmt_pkg::OFFSET_RESET;
         jump_thr   = mrmt_pkg::THRESHOLD_RESET;
         revs       = 0;
         prev_pos   = 0;
         cenc       = 0;
         last_speed = '0;
         errors     = 0;
      endfunction

      function void write_reg(mrmt_pkg::csr_index_type idx,
                              logic [mrmt_pkg::WORD_W-1:0] data);
         case (idx)
            mrmt_pkg::CSR_MOTOR_ID:  motor_id = data[mrmt_pkg::MOTOR_W-1:0];
            mrmt_pkg::CSR_OFFSET:    enc_offset = data;
            mrmt_pkg::CSR_THRESHOLD: jump_thr = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function longint turn_position();
         return longint'(revs) * 65536 + longint'(cenc);
      endfunction

      // accepted frame: run the unwrap and queue the reply it must produce
      function void note_frame(logic [mrmt_pkg::ID_W-1:0] fid,
                               logic [mrmt_pkg::WORD_W-1:0] spd,
                               logic [mrmt_pkg::WORD_W-1:0] enc);
         reply_type r;
         longint    pos;
         longint    thr;
         logic      hit;
         hit = (int'(fid) == int'(mrmt_pkg::REPLY_ID_BASE) + int'(motor_id));
         thr = longint'(jump_thr);
         if (hit) begin
            last_speed = spd;
            cenc       = int'(enc) - int'(enc_offset);
         end
         pos = turn_position();
         // big fall: wrapped forward
         if (pos - prev_pos < -thr) begin
            if (revs < TURN_MAX) revs++;
            pos = turn_position();
         end
         // big rise (after the first fix): wrapped backward
         if (pos - prev_pos > thr) begin
            if (revs > TURN_MIN) revs--;
            pos = turn_position();
         end
         prev_pos  = pos;
         r.matched = hit;
         r.speed   = last_speed;
         r.pos     = pos[mrmt_pkg::POS_W-1:0];
         r.turns   = revs[mrmt_pkg::WORD_W-1:0];
         owed.push_back(r);
      endfunction

      task report(string text);
         $display("%0t ns reply error: %s", $time, text);
         errors++;
      endtask

      task check_reply(reply_type got);
         reply_type want;
         if (owed.size() == 0) begin
            report($sformatf("beat with nothing outstanding (pos %0d)", got.pos));
         end else begin
            want = owed.pop_front();
            if (got.matched !== want.matched)
               report($sformatf("id_matched %b, want %b", got.matched, want.matched));
            if (got.speed !== want.speed)
               report($sformatf("speed_out %h, want %h", got.speed, want.speed));
            if (got.pos !== want.pos)
               report($sformatf("position_counts %0d, want %0d", got.pos, want.pos));
            if (got.turns !== want.turns)
               report($sformatf("turn_count %0d, want %0d", got.turns, want.turns));
         end
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [mrmt_pkg::ID_W-1:0]          req_frame_id;
   logic [mrmt_pkg::WORD_W-1:0]        req_speed_word;
   logic [mrmt_pkg::WORD_W-1:0]        req_encoder_word;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic                               rsp_id_matched;
   logic [mrmt_pkg::WORD_W-1:0]        rsp_speed_out;
   logic signed [mrmt_pkg::POS_W-1:0]  rsp_position_counts;
   logic signed [mrmt_pkg::WORD_W-1:0] rsp_turn_count;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [mrmt_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [mrmt_pkg::WORD_W-1:0]        csr_data;

   tracker_scoreboard_type sb;
   logic                   send_idling;
   logic                   rsp_idling;
   logic                   hold_request;

   motor_reply_multiturn_tracker_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_id        (req_frame_id),
      .req_speed_word      (req_speed_word),
      .req_encoder_word    (req_encoder_word),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_id_matched      (rsp_id_matched),
      .rsp_speed_out       (rsp_speed_out),
      .rsp_position_counts (rsp_position_counts),
      .rsp_turn_count      (rsp_turn_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   // frame identifier the block currently answers to
   function automatic logic [mrmt_pkg::ID_W-1:0] own_id();
      logic [mrmt_pkg::ID_W-1:0] id;
      id = 11'(mrmt_pkg::REPLY_ID_BASE + sb.motor_id);
      return id;
   endfunction

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // offer one frame, hold it until the beat, then maybe idle
   task automatic send_frame(logic [mrmt_pkg::ID_W-1:0] fid,
                             logic [mrmt_pkg::WORD_W-1:0] spd,
                             logic [mrmt_pkg::WORD_W-1:0] enc);
      req_valid        <= 1'b1;
      req_frame_id     <= fid;
      req_speed_word   <= spd;
      req_encoder_word <= enc;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_frame(fid, spd, enc);
      if (send_idling && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 12));
   endtask

   task automatic write_reg(mrmt_pkg::csr_index_type idx,
                            logic [mrmt_pkg::WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [mrmt_pkg::MOTOR_W-1:0] motor,
                             logic [mrmt_pkg::WORD_W-1:0] offset,
                             logic [mrmt_pkg::WORD_W-1:0] thr);
      write_reg(mrmt_pkg::CSR_MOTOR_ID, 16'(motor));
      write_reg(mrmt_pkg::CSR_OFFSET, offset);
      write_reg(mrmt_pkg::CSR_THRESHOLD, thr);
   endtask

   // stop offering and let every owed reply come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side ready: random stalls, plus one long stall on request
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_request = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // result beat monitor
   initial begin
      reply_type got;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            got.matched = rsp_id_matched;
            got.speed   = rsp_speed_out;
            got.pos     = rsp_position_counts;
            got.turns   = rsp_turn_count;
            sb.check_reply(got);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int                          phase;
      int                          sent;
      int                          pick;
      int                          step;
      int                          thr;
      int                          walk;
      int                          turn;
      int                          k;
      logic [mrmt_pkg::ID_W-1:0]   fid;
      logic [mrmt_pkg::WORD_W-1:0] enc;
      logic [mrmt_pkg::WORD_W-1:0] offset;
      logic [mrmt_pkg::WORD_W-1:0] thr_val;

      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_frame_id     = '0;
      req_speed_word   = '0;
      req_encoder_word = '0;
      csr_valid        = 1'b0;
      csr_index        = mrmt_pkg::CSR_MOTOR_ID;
      csr_data         = '0;
      send_idling      = 1'b0;
      rsp_idling       = 1'b0;
      hold_request     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: wraps both ways, threshold edges, foreign frames
      send_frame(own_id(), 16'hFFFF, 16'd0);
      send_frame(own_id(), 16'h0000, 16'hFFFF);
      send_frame(own_id(), 16'h1234, 16'd0);
      send_frame(own_id(), 16'h8000, mrmt_pkg::THRESHOLD_RESET);
      send_frame(own_id(), 16'h0001, 16'd0);
      send_frame(own_id(), 16'h7FFF, mrmt_pkg::THRESHOLD_RESET + 16'd1);
      send_frame(own_id() - 11'd1, 16'hAAAA, 16'h5555);
      send_frame(own_id() + 11'd1, 16'h5555, 16'hAAAA);
      send_frame(11'd0, 16'hFFFF, 16'hFFFF);
      send_frame(11'h7FF, 16'hFFFF, 16'hFFFF);
      send_frame(own_id() | 11'h400, 16'h0F0F, 16'd0);

      // top motor id, full offset, zero threshold
      wait_drained();
      set_config(5'd31, 16'hFFFF, 16'd0);
      send_frame(own_id(), 16'h0000, 16'd0);
      send_frame(own_id(), 16'hFFFF, 16'hFFFF);
      send_frame(own_id(), 16'h1111, 16'h8000);
      send_frame(own_id(), 16'h2222, 16'h8001);
      send_frame(own_id() + 11'd1, 16'h3333, 16'd0);
      send_frame(11'(mrmt_pkg::REPLY_ID_BASE), 16'h4444, 16'd0);

      // motor zero, no offset, widest threshold
      wait_drained();
      set_config(5'd0, 16'd0, 16'hFFFF);
      send_frame(own_id(), 16'h8001, 16'hFFFF);
      send_frame(own_id(), 16'h7FFE, 16'd0);
      send_frame(11'h7FF, 16'h0000, 16'd0);
      send_frame(own_id(), 16'hC3C3, 16'h8000);

      // random phases, mostly a turning shaft with foreign frames mixed in
      walk = 0;
      for (phase = 0; phase < 8; phase++) begin
         wait_drained();
         offset = (phase == 1) ? 16'hFFFF
                : (phase == 3) ? 16'd0 : 16'($urandom_range(0, 65535));
         case (phase)
            0:       thr_val = mrmt_pkg::THRESHOLD_RESET;
            4:       thr_val = 16'd0;
            5:       thr_val = 16'hFFFF;
            default: thr_val = 16'($urandom_range(0, 12000));
         endcase
         set_config((phase == 6) ? 5'd31 : (phase == 7) ? 5'd0 : 5'($urandom_range(0, 31)),
                    offset, thr_val);
         send_idling = (phase % 3 != 1) && (phase != 2);
         rsp_idling  = (phase % 4 != 3);
         // long result stall with the sender still pushing
         if (phase == 2) hold_request = 1'b1;
         sent = 0;
         while (sent < 40) begin
            pick = $urandom_range(0, 19);
            thr  = int'(sb.jump_thr);
            if (pick < 14) begin
               case ($urandom_range(0, 3))
                  0:       step = int'($urandom_range(0, thr));
                  1:       step = thr - 1 + int'($urandom_range(0, 2));
                  2:       step = int'($urandom_range(0, 65535));
                  default: step = 65536 - int'($urandom_range(0, thr));
               endcase
               if ($urandom_range(0, 1) == 1) step = -step;
               walk = (walk + step) & 32'hFFFF;
               enc  = walk[mrmt_pkg::WORD_W-1:0];
               fid  = own_id();
            end else begin
               enc = 16'($urandom_range(0, 65535));
               case (pick)
                  17:      fid = ($urandom_range(0, 1) == 1) ? own_id() + 11'd1
                                                             : own_id() - 11'd1;
                  18:      fid = own_id() ^ (11'd1 << $urandom_range(0, mrmt_pkg::ID_W - 1));
                  19:      fid = own_id();
                  default: fid = 11'($urandom_range(0, 2047));
               endcase
            end
            sent++;
            send_frame(fid, 16'($urandom_range(0, 65535)), enc);
         end
      end

      // full-rate spin: a dozen turns forward, then a dozen back
      wait_drained();
      send_idling = 1'b0;
      rsp_idling  = 1'b0;
      set_config(5'd1, 16'd0, 16'h7FFF);
      for (turn = 0; turn < 12; turn++) begin
         for (k = 0; k < 3; k++) begin
            enc = 16'(k * SPIN_STEP);
            send_frame(own_id(), 16'($urandom_range(0, 65535)), enc);
         end
      end
      for (turn = 0; turn < 12; turn++) begin
         for (k = 2; k >= 0; k--) begin
            enc = 16'(k * SPIN_STEP);
            send_frame(own_id(), 16'($urandom_range(0, 65535)), enc);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
